// File: sv/strs_pkg.sv
`timescale 1ns / 1ps
package strs_pkg;

  localparam int TableDepth = 1024;
  localparam int ScoreW     = 16;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int SumW       = ScoreW + AddrW;
  localparam int ResW       = 23;

  // rounding scale factors for average and percent
  localparam int Hundred    = 100;
  localparam int PctScale   = 10000;
  localparam int MulBW      = $clog2(PctScale + 1);
  localparam int NumW       = SumW + MulBW + 1;
  localparam int DivCntW    = $clog2(NumW);

  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  localparam int CfgAddrW   = 3;

  typedef enum logic [2:0] {
    ActLoad    = 3'd0,
    ActAverage = 3'd1,
    ActMin     = 3'd2,
    ActMax     = 3'd3,
    ActAbove   = 3'd4,
    ActBelow   = 3'd5,
    ActEqual   = 3'd6,
    ActAdvance = 3'd7
  } action_e;

  typedef enum logic {
    RegEntryCount     = 1'b0,
    RegReferenceScore = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkScan,
    BkLast,
    BkMul,
    BkDiv,
    BkFin
  } back_state_e;

  // classified command handed from front to back
  typedef struct packed {
    action_e            act;
    logic               err;
    logic [AddrW-1:0]   lo;
    logic [AddrW-1:0]   hi;
    logic [ScoreW-1:0]  score;
    logic [ScoreW-1:0]  ref_score;
    logic [CntW-1:0]    k;
  } cmd_t;

endpackage

// File: sv/score_table_range_stats.sv
`timescale 1ns / 1ps
// Load or rejected item: the back end pops it while idle and registers the result strobe.
// Min/max/count/advance: scan of the L entries in BkScan, then BkLast and BkFin;
// average and percent add BkMul and the bit-serial divide in BkDiv before BkFin.
// Throughput is set by the one-entry-per-cycle RAM scan; 2 items queue ahead.
// Reset (rst_ni, async, active low) clears control and registers; table is
// undefined until loaded. done_o is a one-cycle strobe; the receiver cannot stall.
module score_table_range_stats (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    action_i,
  input  logic [9:0]                    low_index_i,
  input  logic [9:0]                    high_index_i,
  input  logic [15:0]                   score_in_i,
  input  logic [10:0]                   advance_slots_i,
  // result channel
  output logic                          done_o,
  output logic [22:0]                   result_value_o,
  output logic                          advances_o,
  output logic                          error_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [strs_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import strs_pkg::*;

  // configuration registers, to be written only while idle; the block does not enforce this
  logic [10:0] entry_count_q;
  logic [15:0] reference_score_q;
  logic        cfg_wr;
  cfg_reg_e    cfg_sel;

  // front/back hookup
  logic              q_empty, q_pop;
  cmd_t              q_head;
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [ScoreW-1:0] ram_wdata, ram_rdata;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q     <= '0;
      reference_score_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        RegEntryCount:     entry_count_q     <= pwdata[10:0];
        RegReferenceScore: reference_score_q <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegEntryCount:     prdata = 32'(entry_count_q);
      RegReferenceScore: prdata = 32'(reference_score_q);
    endcase
  end

  // front: takes the transfer, checks bounds, queues the command
  strs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .low_index_i       (low_index_i),
    .high_index_i      (high_index_i),
    .score_in_i        (score_in_i),
    .advance_slots_i   (advance_slots_i),
    .entry_count_i     (entry_count_q),
    .reference_score_i (reference_score_q),
    .pop_i             (q_pop),
    .empty_o           (q_empty),
    .head_o            (q_head)
  );

  // back: table writes, range scan, rounding divide, result strobe
  strs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .advances_o     (advances_o),
    .error_o        (error_o)
  );

  // score table
  strs_ram #(
    .Width (ScoreW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: sv/strs_ram.sv
`timescale 1ns / 1ps
module strs_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/strs_front.sv
`timescale 1ns / 1ps
module strs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 action_i,
  input  logic [9:0]                 low_index_i,
  input  logic [9:0]                 high_index_i,
  input  logic [15:0]                score_in_i,
  input  logic [10:0]                advance_slots_i,
  input  logic [10:0]                entry_count_i,
  input  logic [15:0]                reference_score_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output strs_pkg::cmd_t             head_o
);
  import strs_pkg::*;

  cmd_t            q_mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic            push;
  cmd_t            cmd;
  logic [CntW-1:0] n;
  logic [CntW-1:0] lo_ext, hi_ext, slots_ext;
  action_e         act;

  assign act       = action_e'(action_i);
  assign n         = (32'(entry_count_i) > TableDepth) ? CntW'(TableDepth)
                                                       : CntW'(entry_count_i);
  assign lo_ext    = CntW'(low_index_i);
  assign hi_ext    = CntW'(high_index_i);
  assign slots_ext = CntW'(advance_slots_i);

  // classify: error check, scan bounds, clamped k
  always_comb begin
    cmd           = '0;
    cmd.act       = act;
    cmd.score     = ScoreW'(score_in_i);
    cmd.ref_score = ScoreW'(reference_score_i);
    cmd.k         = (slots_ext > n) ? n : slots_ext;
    priority if (act == ActLoad) begin
      cmd.err = (32'(low_index_i) >= TableDepth);
      cmd.lo  = AddrW'(low_index_i);
    end else if (n == '0) begin
      cmd.err = 1'b1;
    end else if (act == ActAverage || act == ActMin || act == ActMax) begin
      cmd.err = (lo_ext > hi_ext) || (hi_ext >= n);
      cmd.lo  = AddrW'(low_index_i);
      cmd.hi  = AddrW'(high_index_i);
    end else begin
      cmd.lo  = '0;
      cmd.hi  = AddrW'(n - 1'b1);
    end
  end

  assign busy    = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign push    = start && !busy;
  assign head_o  = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow a lone push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// File: sv/strs_back.sv
`timescale 1ns / 1ps
module strs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  strs_pkg::cmd_t                head_i,
  output logic                          pop_o,
  output logic                          ram_we_o,
  output logic [strs_pkg::AddrW-1:0]    ram_waddr_o,
  output logic [strs_pkg::ScoreW-1:0]   ram_wdata_o,
  output logic                          ram_re_o,
  output logic [strs_pkg::AddrW-1:0]    ram_raddr_o,
  input  logic [strs_pkg::ScoreW-1:0]   ram_rdata_i,
  output logic                          done_o,
  output logic [22:0]                   result_value_o,
  output logic                          advances_o,
  output logic                          error_o
);
  import strs_pkg::*;

  back_state_e         state_q, state_d;
  cmd_t                cur_q;
  logic [AddrW-1:0]    ptr_q;
  logic [CntW-1:0]     len_q, len_d;
  logic [SumW-1:0]     sum_q;
  logic [ScoreW-1:0]   min_q, max_q;
  logic [CntW-1:0]     above_q, below_q, equal_q;
  logic                data_vld_q;
  logic [NumW-1:0]     num_q, num_d;
  logic [CntW-1:0]     rem_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic                done_q, adv_q, err_q;
  logic [ResW-1:0]     value_q;

  logic                load_cur, emit, emit_adv, emit_err, need_div;
  logic [ResW-1:0]     emit_value;
  logic [SumW-1:0]     mul_a;
  logic [MulBW-1:0]    mul_b;
  logic [SumW+MulBW-1:0] prod;
  logic [CntW:0]       rem_sh;
  logic                q_bit;

  assign len_d    = CntW'(head_i.hi) - CntW'(head_i.lo) + 1'b1;
  assign need_div = (cur_q.act == ActAverage) || (cur_q.act == ActBelow);

  // scaled numerator with half-divisor rounding term
  assign mul_a = (cur_q.act == ActAverage) ? sum_q : SumW'(below_q);
  assign mul_b = (cur_q.act == ActAverage) ? MulBW'(Hundred) : MulBW'(PctScale);
  assign prod  = mul_a * mul_b;
  assign num_d = NumW'(prod) + NumW'(len_q >> 1);

  // restoring divide, one quotient bit per cycle
  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign q_bit  = (rem_sh >= {1'b0, len_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: if (load_cur) state_d = BkScan;
      BkScan: if (ptr_q == cur_q.hi) state_d = BkLast;
      BkLast: state_d = need_div ? BkMul : BkFin;
      BkMul:  state_d = BkDiv;
      BkDiv:  if (div_cnt_q == '0) state_d = BkFin;
      BkFin:  state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    pop_o      = (state_q == BkIdle) && !empty_i;
    load_cur   = pop_o && !head_i.err && (head_i.act != ActLoad);
    ram_we_o   = pop_o && !head_i.err && (head_i.act == ActLoad);
    ram_re_o   = (state_q == BkScan);
    emit       = (pop_o && !load_cur) || (state_q == BkFin);
    emit_err   = (state_q == BkIdle) && head_i.err;
    emit_adv   = 1'b0;
    emit_value = '0;
    if (state_q == BkFin) begin
      unique case (cur_q.act)
        ActAverage, ActBelow: emit_value = num_q[ResW-1:0];
        ActMin:     emit_value = ResW'(min_q);
        ActMax:     emit_value = ResW'(max_q);
        ActAbove:   emit_value = ResW'(above_q);
        ActEqual:   emit_value = ResW'(equal_q);
        ActAdvance: emit_adv   = (above_q < cur_q.k);
        ActLoad:    emit_value = '0;
      endcase
    end
  end

  assign ram_waddr_o = head_i.lo;
  assign ram_wdata_o = head_i.score;
  assign ram_raddr_o = ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BkIdle;
      data_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      data_vld_q <= ram_re_o;
      done_q     <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= emit_value;
    adv_q   <= emit_adv;
    err_q   <= emit_err;
    if (load_cur) begin
      cur_q   <= head_i;
      ptr_q   <= head_i.lo;
      len_q   <= len_d;
      sum_q   <= '0;
      min_q   <= '1;
      max_q   <= '0;
      above_q <= '0;
      below_q <= '0;
      equal_q <= '0;
    end else if (state_q == BkScan) begin
      ptr_q <= ptr_q + 1'b1;
    end
    if (data_vld_q) begin
      sum_q <= sum_q + SumW'(ram_rdata_i);
      if (ram_rdata_i < min_q) min_q <= ram_rdata_i;
      if (ram_rdata_i > max_q) max_q <= ram_rdata_i;
      priority if (ram_rdata_i > cur_q.ref_score) begin
        above_q <= above_q + 1'b1;
      end else if (ram_rdata_i < cur_q.ref_score) begin
        below_q <= below_q + 1'b1;
      end else begin
        equal_q <= equal_q + 1'b1;
      end
    end
    if (state_q == BkMul) begin
      num_q     <= num_d;
      rem_q     <= '0;
      div_cnt_q <= DivCntW'(NumW - 1);
    end else if (state_q == BkDiv) begin
      num_q     <= {num_q[NumW-2:0], q_bit};
      rem_q     <= q_bit ? CntW'(rem_sh - {1'b0, len_q}) : CntW'(rem_sh);
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = value_q;
  assign advances_o     = adv_q;
  assign error_o        = err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == BkIdle)
    else $error("result strobe outside idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkScan |-> ptr_q <= cur_q.hi)
    else $error("scan pointer ran past upper bound");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_vld_q |-> state_q == BkScan || state_q == BkLast)
    else $error("read data returned outside scan");

endmodule

// File: sim/score_table_range_stats_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the score table range statistics engine.
// Commands go in on the start/busy handshake, results come back on the done_o strobe and are
// matched in order against a local model of the table and its two registers.
module score_table_range_stats_tb;

  localparam int TableDepth = strs_pkg::TableDepth;

  // one command transfer, at the port widths
  typedef struct packed {
    strs_pkg::action_e act;
    logic [9:0]        lo;
    logic [9:0]        hi;
    logic [15:0]       score;
    logic [10:0]       slots;
  } score_cmd_t;

  // one result transfer
  typedef struct packed {
    logic [22:0] value;
    logic        advances;
    logic        error;
  } stats_t;

  // a row of the directed table: a register write, or a command with an optional
  // hand-typed answer (otherwise the model's answer is used)
  typedef struct {
    bit                 is_cfg;
    strs_pkg::cfg_reg_e sel;
    int unsigned        val;
    score_cmd_t         cmd;
    bit                 typed;
    stats_t             want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  action_i;
  logic [9:0]  low_index_i;
  logic [9:0]  high_index_i;
  logic [15:0] score_in_i;
  logic [10:0] advance_slots_i;
  logic        done_o;
  logic [22:0] result_value_o;
  logic        advances_o;
  logic        error_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [strs_pkg::CfgAddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  score_table_range_stats dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .low_index_i    (low_index_i),
    .high_index_i   (high_index_i),
    .score_in_i     (score_in_i),
    .advance_slots_i(advance_slots_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .advances_o     (advances_o),
    .error_o        (error_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // model state: table contents and the two registers as last written
  logic [15:0] table_model [TableDepth];
  logic [10:0] count_model;
  logic [15:0] ref_model;

  stats_t      pending_stats [$];   // answers still owed by the block, oldest first
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;     // chance per command of a gap before it
  int unsigned loaded_upto;         // entries 0..loaded_upto-1 have all been written
  dir_row_t    directed_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop, well past the slowest legal run
  initial begin
    #30_000_000;
    $display("score_table_range_stats regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model: one call per accepted command, in acceptance order.
  // ---------------------------------------------------------------------------
  function automatic stats_t predict_stats(score_cmd_t c);
    stats_t          r;
    int unsigned     n;
    longint unsigned acc;
    longint unsigned len;
    int unsigned     above;
    int unsigned     below;
    int unsigned     equal;
    int unsigned     k;
    r     = '0;
    above = 0;
    below = 0;
    equal = 0;
    // counts above the table size act as a full table
    n = (count_model > TableDepth) ? TableDepth : count_model;
    if (c.act == strs_pkg::ActLoad) begin
      table_model[c.lo] = c.score;   // loads ignore the entry count
    end else if (n == 0) begin
      r.error = 1'b1;
    end else if (c.act <= strs_pkg::ActMax) begin
      if (c.lo > c.hi || c.hi >= n) begin
        r.error = 1'b1;
      end else if (c.act == strs_pkg::ActAverage) begin
        acc = 0;
        for (int i = c.lo; i <= c.hi; i++) acc += table_model[i];
        len     = c.hi - c.lo + 1;
        // hundredths, half rounds up
        r.value = 23'((acc * strs_pkg::Hundred + len / 2) / len);
      end else begin
        acc = table_model[c.lo];
        for (int i = c.lo + 1; i <= c.hi; i++) begin
          if (c.act == strs_pkg::ActMin ? table_model[i] < acc : table_model[i] > acc)
            acc = table_model[i];
        end
        r.value = 23'(acc);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (table_model[i] > ref_model) above++;
        else if (table_model[i] < ref_model) below++;
        else equal++;
      end
      case (c.act)
        strs_pkg::ActAbove: r.value = 23'(above);
        strs_pkg::ActBelow: begin
          acc     = longint'(below) * strs_pkg::PctScale + n / 2;
          r.value = 23'(acc / n);
        end
        strs_pkg::ActEqual: r.value = 23'(equal);
        default: begin
          // advance: fewer than k scores strictly higher; k clamps to the count
          k          = (c.slots > n) ? n : c.slots;
          r.advances = (above < k);
        end
      endcase
    end
    return r;
  endfunction

  function automatic score_cmd_t mk_cmd(strs_pkg::action_e act, int unsigned lo,
                                        int unsigned hi, int unsigned score,
                                        int unsigned slots);
    score_cmd_t c;
    c.act   = act;
    c.lo    = lo[9:0];
    c.hi    = hi[9:0];
    c.score = score[15:0];
    c.slots = slots[10:0];
    return c;
  endfunction

  function automatic dir_row_t q_row(strs_pkg::action_e act, int unsigned lo, int unsigned hi,
                                     int unsigned score, int unsigned slots);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.sel    = strs_pkg::RegEntryCount;
    r.val    = 0;
    r.cmd    = mk_cmd(act, lo, hi, score, slots);
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic dir_row_t t_row(strs_pkg::action_e act, int unsigned lo, int unsigned hi,
                                     int unsigned score, int unsigned slots,
                                     int unsigned value, bit adv, bit err);
    dir_row_t r;
    r       = q_row(act, lo, hi, score, slots);
    r.typed = 1'b1;
    r.want  = '{value: value[22:0], advances: adv, error: err};
    return r;
  endfunction

  function automatic dir_row_t c_row(strs_pkg::cfg_reg_e sel, int unsigned val);
    dir_row_t r;
    r        = q_row(strs_pkg::ActLoad, 0, 0, 0, 0);
    r.is_cfg = 1'b1;
    r.sel    = sel;
    r.val    = val;
    return r;
  endfunction

  // scores biased toward extremes, the reference and small values so ties happen
  function automatic int unsigned pick_score();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1:       return ref_model;
      2:       return $urandom_range(0, 15);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic int unsigned pick_ref();
    int unsigned n;
    n = (count_model > TableDepth) ? TableDepth : count_model;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return (n > 0) ? table_model[$urandom_range(0, n - 1)] : $urandom_range(0, 16'hFFFF);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Random command. Mostly well-formed ranges inside the loaded part; some loads anywhere,
  // some broken ranges. Unused fields carry noise.
  function automatic score_cmd_t rand_cmd();
    score_cmd_t  c;
    int unsigned n;
    int unsigned m;
    n       = (count_model > TableDepth) ? TableDepth : count_model;
    m       = (n == 0) ? 1 : n;
    c.lo    = 10'($urandom);
    c.hi    = 10'($urandom);
    c.score = 16'($urandom);
    c.slots = 11'($urandom);
    if ($urandom_range(0, 99) < 20) begin
      c.act   = strs_pkg::ActLoad;
      c.score = 16'(pick_score());
      if ($urandom_range(0, 3) != 0) c.lo = 10'($urandom_range(0, m - 1));
    end else begin
      c.act = strs_pkg::action_e'($urandom_range(1, 7));
      if (c.act <= strs_pkg::ActMax && $urandom_range(0, 99) >= 15) begin
        c.lo = 10'($urandom_range(0, m - 1));
        c.hi = ($urandom_range(0, 5) == 0) ? c.lo : 10'($urandom_range(c.lo, m - 1));
      end
      if (c.act == strs_pkg::ActAdvance && $urandom_range(0, 3) != 0)
        c.slots = 11'($urandom_range(0, m + 1));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Everything is driven on the falling edge; a transfer happens at
  // the rising edge where start is high and busy is low. start stays high across
  // back-to-back transfers, so each edge sees a single assignment to it.
  // ---------------------------------------------------------------------------
  task automatic send_item(score_cmd_t c, bit typed, stats_t want);
    int unsigned gap;
    stats_t      predicted;
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      start           <= 1'b0;
      action_i        <= 3'($urandom);
      low_index_i     <= 10'($urandom);
      high_index_i    <= 10'($urandom);
      score_in_i      <= 16'($urandom);
      advance_slots_i <= 11'($urandom);
    end
    @(negedge clk_i);
    start           <= 1'b1;
    action_i        <= c.act;
    low_index_i     <= c.lo;
    high_index_i    <= c.hi;
    score_in_i      <= c.score;
    advance_slots_i <= c.slots;
    do @(posedge clk_i); while (busy);
    predicted = predict_stats(c);
    pending_stats.push_back(typed ? want : predicted);
  endtask

  // drop start, wait for every owed answer, then a short settle
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register write, then read back through the same port
  task automatic cfg_write(strs_pkg::cfg_reg_e sel, int unsigned val);
    logic [31:0] junk;
    logic [31:0] data;
    logic [31:0] readback;
    junk = $urandom;
    // bits above the register width are noise and must be dropped
    data = (sel == strs_pkg::RegEntryCount) ? {junk[31:11], val[10:0]}
                                            : {junk[31:16], val[15:0]};
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == strs_pkg::RegEntryCount) count_model = data[10:0];
    else ref_model = data[15:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = (sel == strs_pkg::RegEntryCount) ? {21'b0, count_model} : {16'b0, ref_model};
    if (prdata !== readback) begin
      $display("%0t register %s readback: expected %0d actual %0d",
               $realtime, sel.name(), readback, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the block cannot be stalled, so every strobe is a transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    stats_t owed;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_stats.size() == 0) begin
        $display("%0t unexpected result: expected none actual value %0d advances %0b error %0b",
                 $realtime, result_value_o, advances_o, error_o);
        mismatch_count++;
      end else begin
        owed = pending_stats.pop_front();
        if (result_value_o !== owed.value) begin
          $display("%0t result_value: expected %0d actual %0d",
                   $realtime, owed.value, result_value_o);
          mismatch_count++;
        end
        if (advances_o !== owed.advances) begin
          $display("%0t advances: expected %0b actual %0b",
                   $realtime, owed.advances, advances_o);
          mismatch_count++;
        end
        if (error_o !== owed.error) begin
          $display("%0t error: expected %0b actual %0b", $realtime, owed.error, error_o);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned idle_plan [4];
    int unsigned want_n;

    idle_plan       = '{0, 82, 0, 32};
    mismatch_count  = 0;
    sender_idle_pct = 0;
    count_model     = '0;
    ref_model       = '0;
    foreach (table_model[i]) table_model[i] = '0;

    rst_ni          = 1'b0;
    start           = 1'b0;
    action_i        = '0;
    low_index_i     = '0;
    high_index_i    = '0;
    score_in_i      = '0;
    advance_slots_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Straight after reset the count is zero: every query is an empty-table
    // error. Then five loads (entries 0-3 and the last) with both score extremes, and the range corner cases.
    directed_rows.push_back(t_row(strs_pkg::ActAverage, 0, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(t_row(strs_pkg::ActMin, 0, 3, 0, 0, 0, 0, 1));
    directed_rows.push_back(t_row(strs_pkg::ActMax, 0, 3, 0, 0, 0, 0, 1));
    directed_rows.push_back(t_row(strs_pkg::ActAbove, 0, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(t_row(strs_pkg::ActBelow, 0, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(t_row(strs_pkg::ActEqual, 0, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(t_row(strs_pkg::ActAdvance, 0, 0, 0, 5, 0, 0, 1));
    directed_rows.push_back(t_row(strs_pkg::ActLoad, 0, 0, 16'hFFFF, 0, 0, 0, 0));
    directed_rows.push_back(t_row(strs_pkg::ActLoad, 1, 0, 16'h0000, 0, 0, 0, 0));
    directed_rows.push_back(t_row(strs_pkg::ActLoad, 2, 0, 1234, 0, 0, 0, 0));
    directed_rows.push_back(t_row(strs_pkg::ActLoad, 3, 0, 16'h8000, 0, 0, 0, 0));
    directed_rows.push_back(t_row(strs_pkg::ActLoad, 1023, 0, 16'h5555, 0, 0, 0, 0));
    directed_rows.push_back(c_row(strs_pkg::RegEntryCount, 4));
    directed_rows.push_back(c_row(strs_pkg::RegReferenceScore, 1234));
    directed_rows.push_back(q_row(strs_pkg::ActAverage, 0, 3, 0, 0));
    directed_rows.push_back(t_row(strs_pkg::ActMin, 0, 3, 0, 0, 0, 0, 0));
    directed_rows.push_back(t_row(strs_pkg::ActMax, 0, 3, 0, 0, 16'hFFFF, 0, 0));
    directed_rows.push_back(q_row(strs_pkg::ActAbove, 0, 0, 0, 0));
    directed_rows.push_back(q_row(strs_pkg::ActBelow, 0, 0, 0, 0));
    directed_rows.push_back(q_row(strs_pkg::ActEqual, 0, 0, 0, 0));
    // zero advancing places never advance
    directed_rows.push_back(t_row(strs_pkg::ActAdvance, 0, 0, 0, 0, 0, 0, 0));
    // more places than entries: clamps to the count
    directed_rows.push_back(q_row(strs_pkg::ActAdvance, 0, 0, 0, 2047));
    // reversed bounds, then upper bound at the count
    directed_rows.push_back(t_row(strs_pkg::ActMin, 2, 1, 0, 0, 0, 0, 1));
    directed_rows.push_back(t_row(strs_pkg::ActMax, 0, 4, 0, 0, 0, 0, 1));
    directed_rows.push_back(q_row(strs_pkg::ActAverage, 3, 3, 0, 0));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain();
        cfg_write(directed_rows[i].sel, directed_rows[i].val);
      end else begin
        send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
      end
    end
    loaded_upto = 4;

    // Random part: sixteen settings, cycling through the sender idle plan. First a single
    // entry, then an empty table, then small random counts. The loaded prefix is extended
    // first, so a query never reads an entry that was never written.
    for (int ph = 0; ph < 16; ph++) begin
      sender_idle_pct = idle_plan[ph % 4];
      want_n = (ph == 0) ? 1 : (ph == 1) ? 0 : $urandom_range(2, 48);
      while (loaded_upto < want_n) begin
        send_item(mk_cmd(strs_pkg::ActLoad, loaded_upto, $urandom, pick_score(), $urandom),
                  1'b0, '0);
        loaded_upto++;
      end
      drain();
      cfg_write(strs_pkg::RegEntryCount, want_n);
      cfg_write(strs_pkg::RegReferenceScore, pick_ref());
      repeat (30) send_item(rand_cmd(), 1'b0, '0);
    end

    // Count at the depth and at the largest value the register holds (clamps to the
    // depth). Only ranges over written entries: the loaded prefix and the last entry.
    sender_idle_pct = 32;
    drain();
    cfg_write(strs_pkg::RegEntryCount, TableDepth);
    send_item(mk_cmd(strs_pkg::ActMax, 1023, 1023, 0, 0), 1'b0, '0);
    send_item(mk_cmd(strs_pkg::ActAverage, 0, loaded_upto - 1, 0, 0), 1'b0, '0);
    drain();
    cfg_write(strs_pkg::RegEntryCount, 2047);
    send_item(mk_cmd(strs_pkg::ActMin, 1023, 1023, 0, 0), 1'b0, '0);
    send_item(mk_cmd(strs_pkg::ActMin, 0, loaded_upto - 1, 0, 0), 1'b0, '0);
    send_item(mk_cmd(strs_pkg::ActMax, 5, 2, 0, 0), 1'b0, '0);

    // wait out every owed answer plus a settle for any stray strobe
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("score_table_range_stats regression: pass");
    end else begin
      $display("score_table_range_stats regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
sv/strs_pkg.sv
sv/strs_ram.sv
sv/strs_front.sv
sv/strs_back.sv
sv/score_table_range_stats.sv
sim/score_table_range_stats_tb.sv
